@@ src/bbd_pkg.sv @@
package bbd_pkg;

	// Default half block size; a full block holds twice this many bytes.
	localparam int HALF_BLOCK_DEF = 5;

	localparam int BYTE_W = 8;

	// Descrambling constants.
	localparam logic [BYTE_W-1:0] HIGH_THRESH = 8'h90;
	localparam logic [BYTE_W-1:0] HIGH_MASK   = 8'hf0;
	localparam logic [BYTE_W-1:0] LOW_MASK    = 8'h0f;
	localparam logic [BYTE_W-1:0] NIBBLE_DEC  = 8'd15;
	localparam logic [BYTE_W-1:0] BYTE_OFFSET = 8'd7;
	localparam int                NIBBLE_W    = 4;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	// Tag that travels alongside an outstanding memory read.
	typedef struct packed {
		logic valid;
		logic last;
	} rd_tag_t;

	function automatic logic [BYTE_W-1:0] descramble(logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] c;
		c = v;
		if (c >= HIGH_THRESH) begin
			c = (c & HIGH_MASK) | ((c + NIBBLE_DEC) & LOW_MASK);
		end
		c = {c[NIBBLE_W-1:0], c[BYTE_W-1:NIBBLE_W]};
		return c + BYTE_OFFSET;
	endfunction

endpackage

@@ src/bbd_if.sv @@
interface bbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source(output valid, output in_byte, output end_of_stream, input ready);
	modport sink(input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface bbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       block_last;

	modport source(output valid, output out_byte, output block_last, input ready);
	modport sink(input valid, input out_byte, input block_last, output ready);
endinterface

@@ src/bbd_ram.sv @@
module bbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/bbd_ctrl.sv @@
module bbd_ctrl #(
	parameter int HALF_BLOCK = bbd_pkg::HALF_BLOCK_DEF,
	localparam int FULL = 2 * HALF_BLOCK,
	localparam int AW   = $clog2(FULL),
	localparam int CW   = $clog2(FULL + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	bbd_in_if.sink           ingress,
	input  logic             out_free,
	output logic             we,
	output logic [AW-1:0]    waddr,
	output logic [7:0]       wdata,
	output logic [AW-1:0]    raddr,
	output bbd_pkg::rd_tag_t rd_s1
);

	bbd_pkg::state_t state_q, state_d;
	logic [AW-1:0]   fill_q;
	logic [AW-1:0]   idx_q;
	logic [CW-1:0]   t_q;
	logic            accept;
	logic            flush;
	logic            issue;
	logic            last_issue;

	// Output position j of a block of t bytes reads buffer entry src_index(j, t).
	function automatic logic [AW-1:0] src_index(logic [AW-1:0] j, logic [CW-1:0] t);
		logic [AW-1:0] k;
		logic [CW-1:0] kn;
		k = j;
		if (t >= CW'(HALF_BLOCK)) begin
			if (j == AW'(0)) begin
				k = AW'(HALF_BLOCK - 1);
			end else if (j == AW'(HALF_BLOCK - 1)) begin
				k = AW'(0);
			end
		end
		if (t == CW'(FULL)) begin
			if (j == AW'(HALF_BLOCK)) begin
				k = AW'(FULL - 1);
			end else if (j == AW'(FULL - 1)) begin
				k = AW'(HALF_BLOCK);
			end
		end
		kn = CW'(k) + CW'(1);
		if (k[0]) begin
			return k - AW'(1);
		end else if (kn < t) begin
			return k + AW'(1);
		end
		return k;
	endfunction

	assign accept     = ingress.valid && ingress.ready;
	assign flush      = ingress.end_of_stream || (fill_q == AW'(FULL - 1));
	assign last_issue = (CW'(idx_q) + CW'(1)) == t_q;

	always_comb begin
		ingress.ready = (state_q == bbd_pkg::ST_FILL);
		issue         = (state_q == bbd_pkg::ST_DRAIN) && !rd_s1.valid && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bbd_pkg::ST_FILL: begin
				if (accept && flush) begin
					state_d = bbd_pkg::ST_DRAIN;
				end
			end
			bbd_pkg::ST_DRAIN: begin
				if (issue && last_issue) begin
					state_d = bbd_pkg::ST_FILL;
				end
			end
			default: state_d = bbd_pkg::ST_FILL;
		endcase
	end

	assign we    = accept;
	assign waddr = fill_q;
	assign wdata = ingress.in_byte;
	assign raddr = src_index(idx_q, t_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbd_pkg::ST_FILL;
			fill_q  <= '0;
			idx_q   <= '0;
			t_q     <= '0;
			rd_s1   <= '0;
		end else begin
			state_q <= state_d;
			rd_s1   <= '{valid: issue, last: last_issue};
			if (accept) begin
				if (flush) begin
					fill_q <= '0;
					t_q    <= CW'(fill_q) + CW'(1);
					idx_q  <= '0;
				end else begin
					fill_q <= fill_q + AW'(1);
				end
			end else if (issue) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < AW'(FULL))
		else $error("fill pointer out of range");

	a_drain_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbd_pkg::ST_DRAIN) |-> (t_q != '0 && CW'(idx_q) < t_q))
		else $error("drain index outside the block");

	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1.valid |=> !rd_s1.valid)
		else $error("two reads in flight");

	a_drain_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbd_pkg::ST_DRAIN) |-> (fill_q == '0))
		else $error("fill pointer not cleared for the next block");
`endif

endmodule

@@ src/block_byte_descrambler.sv @@
// Block byte descrambler. Scrambled bytes arrive as ingress transactions and are
// written into a 2*HALF_BLOCK byte buffer memory at one per cycle while a block
// is being collected. A byte that fills the buffer, or a byte flagged
// end_of_stream, closes the block of t bytes (the flagged byte included). The
// block is then read back through a reorder map (neighboring pairs swapped,
// then byte 0 with byte HALF_BLOCK-1 when t >= HALF_BLOCK, and byte HALF_BLOCK
// with the last byte when the block is full), each byte is descrambled and
// sent as one egress transaction, with block_last set on the final byte. While
// a block is being emitted no ingress transaction is taken. Emission is paced
// by the registered read of the buffer memory with a single read in flight:
// a byte is read only once the previous one has landed in the output register
// and the register is free; egress backpressure holds it further. Once the
// last read of a block is issued, collection of the next block resumes while
// the final byte still waits in the output register.
module block_byte_descrambler #(
	parameter int HALF_BLOCK = bbd_pkg::HALF_BLOCK_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bbd_in_if.sink    ingress,
	bbd_out_if.source egress
);

	localparam int FULL = 2 * HALF_BLOCK;
	localparam int AW   = $clog2(FULL);

	logic                          we;
	logic [AW-1:0]                 waddr;
	logic [bbd_pkg::BYTE_W-1:0]    wdata;
	logic [AW-1:0]                 raddr;
	logic [bbd_pkg::BYTE_W-1:0]    rdata;
	bbd_pkg::rd_tag_t              rd_s1;
	logic                          out_free;

	// Output register: holds one descrambled byte until egress takes it.
	logic                          ov_q;
	logic [bbd_pkg::BYTE_W-1:0]    out_byte_q;
	logic                          out_last_q;

	// A read may be issued when the output register is empty now or is being
	// emptied in this cycle, so the data landing next cycle has a free slot.
	assign out_free = !ov_q || egress.ready;

	bbd_ctrl #(
		.HALF_BLOCK(HALF_BLOCK)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.ingress (ingress),
		.out_free(out_free),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rd_s1   (rd_s1)
	);

	bbd_ram #(
		.WIDTH(bbd_pkg::BYTE_W),
		.DEPTH(FULL)
	) u_buf (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// The read data is descrambled on its way into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (rd_s1.valid) begin
			ov_q <= 1'b1;
		end else if (egress.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1.valid) begin
			out_byte_q <= bbd_pkg::descramble(rdata);
			out_last_q <= rd_s1.last;
		end
	end

	assign egress.valid      = ov_q;
	assign egress.out_byte   = out_byte_q;
	assign egress.block_last = out_last_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1.valid |-> !ov_q)
		else $error("read data arrived while the output register was full");

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !(egress.valid && !egress.ready && rd_s1.valid))
		else $error("buffer write overlapped a blocked read");
`endif

endmodule
